>>> hw/rtl/dictionary_substring_detector_assert.svh
// Assertion macros shared by the dictionary substring detector RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef DICTIONARY_SUBSTRING_DETECTOR_ASSERT_SVH
`define DICTIONARY_SUBSTRING_DETECTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define DSD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define DSD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/dsd_pkg.sv
// Package for the dictionary substring detector: field widths, op codes,
// state type, control structs and the case-fold helper. No dependencies.
`timescale 1ns / 1ps

package dsd_pkg;

  localparam int DEF_NUM_PATTERNS = 128;
  localparam int DEF_MAX_LEN      = 16;

  localparam int OP_W    = 2;
  localparam int SLOT_W  = 7;
  localparam int POSN_W  = 4;
  localparam int VALUE_W = 8;

  // Slots reachable through the slot field.
  localparam int SLOT_LIMIT = 2 ** SLOT_W;
  // Patterns whose first byte is below this fold case.
  localparam int FOLD_LIMIT = 128;

  localparam logic [OP_W-1:0] OP_TEXT     = 2'd0;
  localparam logic [OP_W-1:0] OP_PAT_BYTE = 2'd1;
  localparam logic [OP_W-1:0] OP_PAT_LEN  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRAP
  } state_t;

  typedef struct packed {
    logic wr_byte;
    logic wr_len;
    logic rd_en;
  } tbl_ctrl_t;

  typedef struct packed {
    logic busy;
    logic chk;
  } tbl_stat_t;

  typedef struct packed {
    logic shift;
    logic clear;
    logic nocase;
  } cell_ctrl_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    // 'A' .. 'Z' map to 'a' .. 'z'
    if (c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'd32;
    end
    return c;
  endfunction

  function automatic int slot_depth(input int n);
    return (n < SLOT_LIMIT) ? n : SLOT_LIMIT;
  endfunction

  function automatic int idx_w(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

>>> hw/rtl/dsd_ifs.sv
// Stream interfaces of the dictionary substring detector: input word
// channel and result word channel. Depends on dsd_pkg.
`timescale 1ns / 1ps

interface dsd_in_if;
  logic                           valid;
  logic                           ready;
  logic [dsd_pkg::OP_W-1:0]       op;
  logic [dsd_pkg::SLOT_W-1:0]     slot;
  logic [dsd_pkg::POSN_W-1:0]     position;
  logic [dsd_pkg::VALUE_W-1:0]    value;
  logic                           last;

  modport source (output valid, op, slot, position, value, last, input ready);
  modport sink   (input valid, op, slot, position, value, last, output ready);
endinterface

interface dsd_out_if;
  logic valid;
  logic ready;
  logic found;

  modport source (output valid, found, input ready);
  modport sink   (input valid, found, output ready);
endinterface

>>> hw/rtl/dsd_cell.sv
// One history cell of the detector chain: holds one window byte, passes it
// to the next cell on a shift and extends the match chain. Depends on dsd_pkg.
`timescale 1ns / 1ps

module dsd_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  dsd_pkg::cell_ctrl_t ctrl,
  input  logic [7:0]          byte_in,
  output logic [7:0]          byte_out,
  input  logic [7:0]          pat,
  input  logic                mask,
  input  logic                ok_in,
  output logic                ok_out
);

  logic [7:0] hist_r;
  logic [7:0] cmp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
    end else if (ctrl.clear) begin
      hist_r <= '0;
    end else if (ctrl.shift) begin
      hist_r <= byte_in;
    end
  end

  assign byte_out = hist_r;
  assign cmp      = ctrl.nocase ? dsd_pkg::fold(hist_r) : hist_r;
  // positions beyond the pattern length pass the chain untouched
  assign ok_out   = ok_in & (~mask | (cmp == pat));

endmodule

>>> hw/rtl/dsd_table.sv
// Pattern table of the detector: byte and length memories, length valid
// bits, registered read and the alignment stage. Depends on dsd_pkg.
`timescale 1ns / 1ps

`include "dictionary_substring_detector_assert.svh"

module dsd_table #(
  parameter int NUM_PATTERNS = dsd_pkg::DEF_NUM_PATTERNS,
  parameter int MAX_LEN      = dsd_pkg::DEF_MAX_LEN,
  localparam int SLOTS       = dsd_pkg::slot_depth(NUM_PATTERNS),
  localparam int SLOT_AW     = dsd_pkg::idx_w(SLOTS),
  localparam int POS_W       = dsd_pkg::idx_w(MAX_LEN),
  localparam int LEN_W       = $clog2(MAX_LEN + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dsd_pkg::tbl_ctrl_t          ctrl,
  input  logic [SLOT_AW-1:0]          wr_slot,
  input  logic [POS_W-1:0]            wr_pos,
  input  logic [7:0]                  wr_data,
  input  logic [SLOT_AW-1:0]          rd_slot,
  input  logic [LEN_W-1:0]            seen,
  output dsd_pkg::tbl_stat_t          stat,
  output logic [MAX_LEN-1:0][7:0]     al_pat,
  output logic [MAX_LEN-1:0]          al_mask,
  output logic                        al_nocase
);

  logic [MAX_LEN-1:0][7:0] pat_mem [SLOTS];
  logic [LEN_W-1:0]        len_mem [SLOTS];
  logic [SLOTS-1:0]        len_vld_r;

  logic [MAX_LEN-1:0][7:0] row_r;
  logic [LEN_W-1:0]        len_rd_r;
  logic                    vld_rd_r;
  logic                    rd_v_r;

  logic [MAX_LEN-1:0][7:0] al_pat_r, al_pat_nxt;
  logic [MAX_LEN-1:0]      al_mask_r, al_mask_nxt;
  logic                    al_nocase_r, al_nocase_nxt;
  logic                    al_en_r, al_en_nxt;
  logic                    al_v_r;

  logic [LEN_W-1:0]        wr_len_val;
  logic [LEN_W-1:0]        len_eff;
  logic [8*MAX_LEN-1:0]    rev_flat;
  logic [8*MAX_LEN-1:0]    sh_flat;
  logic [LEN_W+2:0]        sh_amt;

  // clamp lengths above the row size
  assign wr_len_val = (32'(wr_data) > MAX_LEN) ? LEN_W'(MAX_LEN) : LEN_W'(wr_data);

  always_ff @(posedge clk) begin
    if (ctrl.wr_byte) begin
      pat_mem[wr_slot][wr_pos] <= wr_data;
    end
    if (ctrl.wr_len) begin
      len_mem[wr_slot] <= wr_len_val;
    end
    if (ctrl.rd_en) begin
      row_r    <= pat_mem[rd_slot];
      len_rd_r <= len_mem[rd_slot];
      vld_rd_r <= len_vld_r[rd_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_vld_r <= '0;
    end else if (ctrl.wr_len) begin
      len_vld_r[wr_slot] <= 1'b1;
    end
  end

  // Align: the newest text byte meets the last pattern byte, so reverse the
  // row and drop the bytes beyond the length.
  assign len_eff = vld_rd_r ? len_rd_r : '0;
  assign sh_amt  = {LEN_W'(MAX_LEN) - len_eff, 3'b000};

  always_comb begin
    for (int i = 0; i < MAX_LEN; i++) begin
      rev_flat[8*i +: 8] = row_r[MAX_LEN-1-i];
    end
    sh_flat       = rev_flat >> sh_amt;
    al_nocase_nxt = row_r[0] < 8'(dsd_pkg::FOLD_LIMIT);
    for (int j = 0; j < MAX_LEN; j++) begin
      al_pat_nxt[j]  = al_nocase_nxt ? dsd_pkg::fold(sh_flat[8*j +: 8]) : sh_flat[8*j +: 8];
      al_mask_nxt[j] = j < int'(len_eff);
    end
    al_en_nxt = (len_eff != '0) && (len_eff <= seen);
  end

  always_ff @(posedge clk) begin
    al_pat_r    <= al_pat_nxt;
    al_mask_r   <= al_mask_nxt;
    al_nocase_r <= al_nocase_nxt;
    al_en_r     <= al_en_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
      al_v_r <= 1'b0;
    end else begin
      rd_v_r <= ctrl.rd_en;
      al_v_r <= rd_v_r;
    end
  end

  assign stat.busy = rd_v_r | al_v_r;
  assign stat.chk  = al_v_r & al_en_r;
  assign al_pat    = al_pat_r;
  assign al_mask   = al_mask_r;
  assign al_nocase = al_nocase_r;

  `DSD_ASSERT_IMP(a_no_rw_clash, ctrl.rd_en, !(ctrl.wr_byte || ctrl.wr_len), "table write during scan")
  `DSD_ASSERT_IMP(a_chk_has_len, stat.chk, al_mask_r[0], "enabled slot without length")

endmodule

>>> hw/rtl/dictionary_substring_detector.sv
// Dictionary substring detector: a pattern write word is written as it is
// accepted. After a text word is accepted, the next word waits for the scan of
// all min(NUM_PATTERNS, 128) slots of the pattern table through its single
// read port, one slot per cycle, and for the read and alignment stages. The window
// of the last MAX_LEN text bytes sits in a chain of MAX_LEN cells; each scanned
// slot is compared against the whole chain at once. The found word appears on
// the result channel after the scan of the byte flagged last; the next word is
// taken while it waits. Patterns are kept across messages; no clearing pass
// follows reset. Depends on dsd_pkg, dsd_ifs, dsd_table and dsd_cell.
`timescale 1ns / 1ps

`include "dictionary_substring_detector_assert.svh"

module dictionary_substring_detector #(
  parameter int NUM_PATTERNS = dsd_pkg::DEF_NUM_PATTERNS,
  parameter int MAX_LEN      = dsd_pkg::DEF_MAX_LEN
) (
  input logic        clk,
  input logic        rst_n,
  dsd_in_if.sink     in_ch,
  dsd_out_if.source  out_ch
);

  localparam int SLOTS   = dsd_pkg::slot_depth(NUM_PATTERNS);
  localparam int SLOT_AW = dsd_pkg::idx_w(SLOTS);
  localparam int POS_W   = dsd_pkg::idx_w(MAX_LEN);
  localparam int LEN_W   = $clog2(MAX_LEN + 1);

  dsd_pkg::state_t     state_r, state_nxt;
  logic [SLOT_AW-1:0]  cnt_r, cnt_nxt;
  logic                last_r, last_nxt;
  logic [LEN_W-1:0]    seen_r, seen_nxt;
  logic                hit_r, hit_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                found_r, found_nxt;

  dsd_pkg::tbl_ctrl_t  tctl;
  dsd_pkg::tbl_stat_t  stat;
  dsd_pkg::cell_ctrl_t cctl;

  logic [MAX_LEN-1:0][7:0] al_pat;
  logic [MAX_LEN-1:0]      al_mask;
  logic                    al_nocase;
  logic [MAX_LEN:0][7:0]   chain_byte;
  logic [MAX_LEN:0]        chain_ok;

  logic in_acc;
  logic slot_ok;
  logic pos_ok;

  assign in_ch.ready = (state_r == dsd_pkg::ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign slot_ok     = 32'(in_ch.slot) < NUM_PATTERNS;
  assign pos_ok      = 32'(in_ch.position) < MAX_LEN;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;
    seen_nxt      = seen_r;
    hit_nxt       = hit_r;
    out_valid_nxt = out_valid_r;
    found_nxt     = found_r;
    tctl          = '0;
    cctl          = '0;
    cctl.nocase   = al_nocase;

    if (stat.chk && chain_ok[MAX_LEN]) begin
      hit_nxt = 1'b1;
    end
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      dsd_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (in_ch.op)
            dsd_pkg::OP_TEXT: begin
              cctl.shift = 1'b1;
              if (seen_r < LEN_W'(MAX_LEN)) begin
                seen_nxt = LEN_W'(seen_r + 1'b1);
              end
              last_nxt  = in_ch.last;
              cnt_nxt   = '0;
              state_nxt = dsd_pkg::ST_SCAN;
            end
            dsd_pkg::OP_PAT_BYTE: tctl.wr_byte = slot_ok && pos_ok;
            dsd_pkg::OP_PAT_LEN:  tctl.wr_len  = slot_ok;
            default: ;
          endcase
        end
      end
      dsd_pkg::ST_SCAN: begin
        tctl.rd_en = 1'b1;
        if (cnt_r == SLOT_AW'(SLOTS - 1)) begin
          state_nxt = dsd_pkg::ST_WRAP;
        end else begin
          cnt_nxt = SLOT_AW'(cnt_r + 1'b1);
        end
      end
      dsd_pkg::ST_WRAP: begin
        // wait for the last slot to leave the table pipeline
        if (!stat.busy) begin
          if (!last_r) begin
            state_nxt = dsd_pkg::ST_IDLE;
          end else if (!out_valid_r || out_ch.ready) begin
            out_valid_nxt = 1'b1;
            found_nxt     = hit_r;
            cctl.clear    = 1'b1;
            seen_nxt      = '0;
            hit_nxt       = 1'b0;
            state_nxt     = dsd_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = dsd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dsd_pkg::ST_IDLE;
      cnt_r       <= '0;
      last_r      <= 1'b0;
      seen_r      <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      last_r      <= last_nxt;
      seen_r      <= seen_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    found_r <= found_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.found = found_r;

  dsd_table #(
    .NUM_PATTERNS (NUM_PATTERNS),
    .MAX_LEN      (MAX_LEN)
  ) u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (tctl),
    .wr_slot   (SLOT_AW'(in_ch.slot)),
    .wr_pos    (POS_W'(in_ch.position)),
    .wr_data   (in_ch.value),
    .rd_slot   (cnt_r),
    .seen      (seen_r),
    .stat      (stat),
    .al_pat    (al_pat),
    .al_mask   (al_mask),
    .al_nocase (al_nocase)
  );

  // cell 0 holds the newest byte
  assign chain_byte[0] = in_ch.value;
  assign chain_ok[0]   = 1'b1;

  for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
    dsd_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (cctl),
      .byte_in  (chain_byte[j]),
      .byte_out (chain_byte[j+1]),
      .pat      (al_pat[j]),
      .mask     (al_mask[j]),
      .ok_in    (chain_ok[j]),
      .ok_out   (chain_ok[j+1])
    );
  end

  `DSD_ASSERT_IMP(a_acc_table_idle, in_acc, !stat.busy, "word accepted during scan")
  `DSD_ASSERT_IMP(a_seen_cap, 1'b1, seen_r <= LEN_W'(MAX_LEN), "byte count above window")
  `DSD_ASSERT_NXT(a_result_source, !out_valid_r && !(state_r == dsd_pkg::ST_WRAP && last_r), !out_valid_r, "result without message end")

endmodule
